[src/pws_pkg.sv]
package pws_pkg;

  // Configuration port geometry
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegDryThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWetThreshold = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxTravel    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSoakExtra    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSettle       = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRest         = 3'd5;
  localparam logic [CfgIdxW-1:0] RegWarmup       = 3'd6;

  // Register reset values
  localparam logic [9:0]  DryThresholdRst = 10'd200;
  localparam logic [9:0]  WetThresholdRst = 10'd600;
  localparam logic [3:0]  MaxTravelRst    = 4'd5;
  localparam logic [3:0]  SoakExtraRst    = 4'd3;
  localparam logic [7:0]  SettleRst       = 8'd60;
  localparam logic [17:0] RestRst         = 18'd172800;
  localparam logic [3:0]  WarmupRst       = 4'd1;

  typedef struct packed {
    logic [9:0]  dry_threshold;
    logic [9:0]  wet_threshold;
    logic [3:0]  max_travel_seconds;
    logic [3:0]  soak_extra_seconds;
    logic [7:0]  settle_seconds;
    logic [17:0] rest_seconds;
    logic [3:0]  warmup_seconds;
  } cfg_t;

  typedef struct packed {
    logic [2:0] valve_mask;
    logic       pump_on;
    logic [2:0] sensor_power_mask;
    logic       sample_request;
    logic [1:0] active_pot;
    logic [2:0] fault_leds;
  } result_t;

endpackage

[src/pws_core.sv]
module pws_core #(
  parameter int POT_COUNT = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            opcode_i,
  input  logic [9:0]      moisture_i,
  input  pws_pkg::cfg_t   cfg_i,
  output pws_pkg::result_t res_o
);
  import pws_pkg::*;

  // Phase codes
  localparam logic [3:0] PhWarmup    = 4'd0;
  localparam logic [3:0] PhCheck     = 4'd1;
  localparam logic [3:0] PhPreFirst  = 4'd2;
  localparam logic [3:0] PhOpenLoop  = 4'd3;
  localparam logic [3:0] PhOpenDone  = 4'd4;
  localparam logic [3:0] PhPrePump   = 4'd5;
  localparam logic [3:0] PhPreSample = 4'd6;
  localparam logic [3:0] PhPreDrain  = 4'd7;
  localparam logic [3:0] PhSettle    = 4'd8;
  localparam logic [3:0] PhDeepOpen  = 4'd9;
  localparam logic [3:0] PhDeepPump  = 4'd10;
  localparam logic [3:0] PhDeepDrain = 4'd11;
  localparam logic [3:0] PhRest      = 4'd12;
  localparam logic [3:0] PhFault     = 4'd13;

  localparam logic [2:0] PotCnt  = 3'(POT_COUNT);
  localparam logic [2:0] AllMask = 3'((1 << POT_COUNT) - 1);

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  pot_q, pot_d;
  logic [17:0] timer_q, timer_d;
  logic [3:0]  tcnt_q, tcnt_d;
  logic        pend_q, pend_d;
  logic        blink_q, blink_d;
  logic [3:0]  travel_q [POT_COUNT];

  logic [3:0]  travel_sel;
  logic [4:0]  deep_len;
  logic [17:0] wait_len;
  logic [17:0] timer_inc;
  logic [3:0]  tcnt_inc;
  logic        is_wait;
  logic        wr_travel;
  logic        zero_run;
  logic [2:0]  pot_bit;

  // Stored travel time of the active pot
  always_comb begin
    travel_sel = '0;
    for (int i = 0; i < POT_COUNT; i++) begin
      if (pot_q == 2'(i)) travel_sel = travel_q[i];
    end
  end

  assign deep_len  = {1'b0, travel_sel} + {1'b0, cfg_i.soak_extra_seconds};
  assign timer_inc = timer_q + 18'd1;
  assign tcnt_inc  = (tcnt_q < 4'd15) ? tcnt_q + 4'd1 : tcnt_q;
  assign is_wait   = phase_q inside {PhWarmup, PhOpenLoop, PhOpenDone, PhPrePump, PhPreDrain,
                                     PhSettle, PhDeepOpen, PhDeepPump, PhDeepDrain, PhRest};

  // Length of the current timed phase, in seconds
  always_comb begin
    case (phase_q)
      PhWarmup:                 wait_len = 18'(cfg_i.warmup_seconds);
      PhSettle:                 wait_len = 18'(cfg_i.settle_seconds);
      PhDeepPump:               wait_len = 18'(deep_len);
      PhRest:                   wait_len = cfg_i.rest_seconds;
      PhPreDrain, PhDeepDrain:  wait_len = 18'd2;
      default:                  wait_len = 18'd1;
    endcase
  end

  // Next state for one event
  always_comb begin
    phase_d   = phase_q;
    pot_d     = pot_q;
    timer_d   = timer_q;
    tcnt_d    = tcnt_q;
    pend_d    = pend_q;
    blink_d   = blink_q;
    wr_travel = 1'b0;
    zero_run  = 1'b0;

    if (phase_q == PhFault) begin
      if (!opcode_i) blink_d = ~blink_q;
    end else if (opcode_i) begin
      case (phase_q)
        PhCheck: begin
          if (moisture_i < cfg_i.dry_threshold) begin
            phase_d = PhPreFirst;
          end else begin
            pend_d   = 1'b0;
            phase_d  = PhDeepOpen;
            timer_d  = '0;
            zero_run = 1'b1;
          end
        end
        PhPreFirst: begin
          tcnt_d  = '0;
          timer_d = '0;
          if (moisture_i < cfg_i.wet_threshold && cfg_i.max_travel_seconds != 4'd0) begin
            phase_d = PhOpenLoop;
          end else begin
            phase_d = PhOpenDone;
          end
        end
        PhPreSample: begin
          tcnt_d  = tcnt_inc;
          timer_d = '0;
          if (moisture_i < cfg_i.wet_threshold && tcnt_inc < cfg_i.max_travel_seconds) begin
            phase_d = PhPrePump;
          end else if (tcnt_inc >= cfg_i.max_travel_seconds) begin
            phase_d = PhFault;
            blink_d = 1'b1;
          end else begin
            phase_d = PhPreDrain;
          end
        end
        default: ;
      endcase
    end else if (is_wait) begin
      timer_d = timer_inc;
      if (timer_inc >= wait_len) begin
        timer_d  = '0;
        zero_run = 1'b1;
        case (phase_q)
          PhWarmup:   phase_d = PhCheck;
          PhOpenLoop: phase_d = PhPrePump;
          PhOpenDone: begin
            if (tcnt_q >= cfg_i.max_travel_seconds) begin
              phase_d = PhFault;
              blink_d = 1'b1;
            end else begin
              phase_d = PhPreDrain;
            end
          end
          PhPrePump:  phase_d = PhPreSample;
          PhPreDrain: begin
            wr_travel = 1'b1;
            phase_d   = PhSettle;
          end
          PhSettle: begin
            pend_d  = 1'b1;
            phase_d = PhDeepOpen;
          end
          PhDeepOpen: phase_d = PhDeepPump;
          PhDeepPump: phase_d = PhDeepDrain;
          PhDeepDrain: begin
            if (pend_q) begin
              pend_d  = 1'b0;
              phase_d = PhDeepOpen;
            end else if ({1'b0, pot_q} + 3'd1 >= PotCnt) begin
              pot_d   = '0;
              phase_d = PhRest;
            end else begin
              pot_d   = pot_q + 2'd1;
              phase_d = PhWarmup;
            end
          end
          default: begin
            pot_d   = '0;
            phase_d = PhWarmup;
          end
        endcase
      end
    end

    // Zero-length waits end in the same step; at most rest then warm-up chain
    if (zero_run) begin
      case (phase_d)
        PhSettle: begin
          if (cfg_i.settle_seconds == 8'd0) begin
            pend_d  = 1'b1;
            phase_d = PhDeepOpen;
          end
        end
        PhDeepPump: begin
          if (deep_len == 5'd0) phase_d = PhDeepDrain;
        end
        PhRest: begin
          if (cfg_i.rest_seconds == 18'd0) begin
            pot_d   = '0;
            phase_d = PhWarmup;
          end
        end
        default: ;
      endcase
      if (phase_d == PhWarmup && cfg_i.warmup_seconds == 4'd0) phase_d = PhCheck;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhWarmup;
      pot_q   <= '0;
      timer_q <= '0;
      tcnt_q  <= '0;
      pend_q  <= 1'b0;
      blink_q <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      pot_q   <= pot_d;
      timer_q <= timer_d;
      tcnt_q  <= tcnt_d;
      pend_q  <= pend_d;
      blink_q <= blink_d;
    end
  end

  // Per-pot travel times
  for (genvar g = 0; g < POT_COUNT; g++) begin : g_travel
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        travel_q[g] <= '0;
      end else if (en_i && wr_travel && pot_q == 2'(g)) begin
        travel_q[g] <= tcnt_q;
      end
    end
  end

  // Outputs as they stand after the event
  assign pot_bit = 3'b001 << pot_d;

  always_comb begin
    res_o            = '0;
    res_o.active_pot = pot_d;
    case (phase_d)
      PhWarmup, PhSettle: res_o.sensor_power_mask = pot_bit;
      PhCheck, PhPreFirst: begin
        res_o.sensor_power_mask = pot_bit;
        res_o.sample_request    = 1'b1;
      end
      PhOpenLoop, PhOpenDone, PhPreDrain, PhDeepOpen, PhDeepDrain: begin
        res_o.sensor_power_mask = pot_bit;
        res_o.valve_mask        = pot_bit;
      end
      PhPrePump, PhDeepPump: begin
        res_o.sensor_power_mask = pot_bit;
        res_o.valve_mask        = pot_bit;
        res_o.pump_on           = 1'b1;
      end
      PhPreSample: begin
        res_o.sensor_power_mask = pot_bit;
        res_o.valve_mask        = pot_bit;
        res_o.pump_on           = 1'b1;
        res_o.sample_request    = 1'b1;
      end
      PhFault: begin
        res_o.valve_mask        = pot_bit;
        res_o.pump_on           = (tcnt_d != 4'd0);
        res_o.sensor_power_mask = blink_d ? AllMask : 3'd0;
        res_o.fault_leds        = blink_d ? 3'd7 : 3'd0;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // Only reset leaves the fault
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhFault) |=> (phase_q == PhFault))
    else $error("fault phase was left");

  // The pot index stays within the pot set
  a_pot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pot_q} < PotCnt))
    else $error("pot index out of range");

  // The rest phase always serves pot zero
  a_rest_pot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhRest) |-> (pot_q == 2'd0))
    else $error("rest with nonzero pot index");
`endif

endmodule

[src/pws_skid.sv]
module pws_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pws_pkg::result_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             stall_i,
  output pws_pkg::result_t data_o
);
  import pws_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;
  logic    out_xfer;

  assign out_xfer = out_valid_q && !stall_i;
  assign full_o   = skid_valid_q;
  assign valid_o  = out_valid_q;
  assign data_o   = out_q;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) skid_valid_q <= 1'b0;
    end else if (push_i) begin
      if (out_valid_q && stall_i) skid_valid_q <= 1'b1;
      else                        out_valid_q  <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) out_q <= skid_q;
    end else if (push_i) begin
      if (out_valid_q && stall_i) skid_q <= data_i;
      else                        out_q  <= data_i;
    end
  end

`ifndef SYNTHESIS
  // The skid stage only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds data with empty output register");

  // A held output with the skid full keeps both entries
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && stall_i) |=> (skid_valid_q && out_valid_q))
    else $error("entry dropped while stalled");

  // Skid data moves to the output on a transfer
  a_skid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !stall_i) |=> (out_valid_q && out_q == $past(skid_q)))
    else $error("skid entry not forwarded");
`endif

endmodule

[src/plant_watering_sequencer_top.sv]
// A result is registered in the output register, or in the skid stage while output is held.
// Throughput: one item per cycle unless stalled; an event's update is one registered pass.
// A two-entry output buffer keeps input transfers going while one result is stalled.
// Reset (rst_ni low, asynchronous): sensor warm-up of pot 0, timers, counts and stored
// travel times cleared, fault cleared, registers back to their defaults, no result pending.
module plant_watering_sequencer_top #(
  parameter int POT_COUNT = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Event input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         opcode_i,
  input  logic [9:0]                   moisture_i,
  // Result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   valve_mask_o,
  output logic                         pump_on_o,
  output logic [2:0]                   sensor_power_mask_o,
  output logic                         sample_request_o,
  output logic [1:0]                   active_pot_o,
  output logic [2:0]                   fault_leds_o,
  // Register writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pws_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pws_pkg::CfgDataW-1:0] cfg_data_i
);
  import pws_pkg::*;

  cfg_t    cfg_q;
  result_t res;
  result_t out_data;
  logic    in_xfer;
  logic    buf_full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign in_xfer     = in_valid_i && !buf_full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dry_threshold      <= DryThresholdRst;
      cfg_q.wet_threshold      <= WetThresholdRst;
      cfg_q.max_travel_seconds <= MaxTravelRst;
      cfg_q.soak_extra_seconds <= SoakExtraRst;
      cfg_q.settle_seconds     <= SettleRst;
      cfg_q.rest_seconds       <= RestRst;
      cfg_q.warmup_seconds     <= WarmupRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDryThreshold: cfg_q.dry_threshold      <= cfg_data_i[9:0];
        RegWetThreshold: cfg_q.wet_threshold      <= cfg_data_i[9:0];
        RegMaxTravel:    cfg_q.max_travel_seconds <= cfg_data_i[3:0];
        RegSoakExtra:    cfg_q.soak_extra_seconds <= cfg_data_i[3:0];
        RegSettle:       cfg_q.settle_seconds     <= cfg_data_i[7:0];
        RegRest:         cfg_q.rest_seconds       <= cfg_data_i;
        RegWarmup:       cfg_q.warmup_seconds     <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and result logic
  pws_core #(
    .POT_COUNT(POT_COUNT)
  ) u_core (
    .clk_i,
    .rst_ni,
    .en_i       (in_xfer),
    .opcode_i,
    .moisture_i,
    .cfg_i      (cfg_q),
    .res_o      (res)
  );

  // Output register with skid stage
  pws_skid u_skid (
    .clk_i,
    .rst_ni,
    .push_i  (in_xfer),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data)
  );

  assign valve_mask_o        = out_data.valve_mask;
  assign pump_on_o           = out_data.pump_on;
  assign sensor_power_mask_o = out_data.sensor_power_mask;
  assign sample_request_o    = out_data.sample_request;
  assign active_pot_o        = out_data.active_pot;
  assign fault_leds_o        = out_data.fault_leds;

endmodule

[dv/plant_watering_sequencer_top_test.sv]
`timescale 1ns / 100ps

module plant_watering_sequencer_top_test;
  import pws_pkg::*;

  localparam int PotCount = 3;
  localparam int LongHoldCycles = 64;
  localparam int MaxReported = 10;

  // Event codes on the opcode field
  localparam logic OpTick   = 1'b0;
  localparam logic OpSample = 1'b1;

  localparam logic [2:0] AllPots  = 3'((1 << PotCount) - 1);
  localparam logic [2:0] LedsLit  = 3'b111;
  localparam logic [3:0] CountCap = 4'd15;

  // Sequencer stages as the predictor tracks them
  typedef enum logic [3:0] {
    PhWarmup, PhCheck, PhPreFirst, PhOpenLoop, PhOpenDone, PhPrePump, PhPreSample,
    PhPreDrain, PhSettle, PhDeepOpen, PhDeepPump, PhDeepDrain, PhRest, PhFault
  } phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                opcode_i = 1'b0;
  logic [9:0]          moisture_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          valve_mask_o;
  logic                pump_on_o;
  logic [2:0]          sensor_power_mask_o;
  logic                sample_request_o;
  logic [1:0]          active_pot_o;
  logic [2:0]          fault_leds_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Predicted register contents and sequencer state
  cfg_t       cur_cfg = {DryThresholdRst, WetThresholdRst, MaxTravelRst, SoakExtraRst,
                         SettleRst, RestRst, WarmupRst};
  phase_e     st_phase = PhWarmup;
  logic [1:0] st_pot = '0;
  logic [17:0] st_timer = '0;
  logic [3:0] st_travel = '0;
  logic [3:0] st_pour [PotCount] = '{default: '0};
  logic       st_again = 1'b0;
  logic       st_blink = 1'b0;

  pws_pkg::result_t due_outputs[$];
  int  error_count = 0;
  bit  calm = 1'b0;
  bit  gapless = 1'b0;
  bit  long_hold_req = 1'b0;

  plant_watering_sequencer_top i_dut (.*);

  initial forever #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Sequencer predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_timed(phase_e p);
    return p inside {PhWarmup, PhOpenLoop, PhOpenDone, PhPrePump, PhPreDrain, PhSettle,
                     PhDeepOpen, PhDeepPump, PhDeepDrain, PhRest};
  endfunction

  function automatic logic [17:0] hold_len(phase_e p);
    case (p)
      PhWarmup:                hold_len = 18'(cur_cfg.warmup_seconds);
      PhSettle:                hold_len = 18'(cur_cfg.settle_seconds);
      PhDeepPump:              hold_len = 18'(st_pour[st_pot]) +
                                          18'(cur_cfg.soak_extra_seconds);
      PhRest:                  hold_len = cur_cfg.rest_seconds;
      PhPreDrain, PhDeepDrain: hold_len = 18'd2;
      default:                 hold_len = 18'd1;
    endcase
  endfunction

  // Count limit check at the end of a pre-water pass
  function automatic void close_pre_loop();
    if (st_travel >= cur_cfg.max_travel_seconds) begin
      st_phase = PhFault;
      st_blink = 1'b1;
    end else begin
      st_phase = PhPreDrain;
    end
  endfunction

  function automatic void finish_hold();
    case (st_phase)
      PhWarmup:   st_phase = PhCheck;
      PhOpenLoop: st_phase = PhPrePump;
      PhOpenDone: close_pre_loop();
      PhPrePump:  st_phase = PhPreSample;
      PhPreDrain: begin
        st_pour[st_pot] = st_travel;
        st_phase = PhSettle;
      end
      PhSettle: begin
        st_again = 1'b1;
        st_phase = PhDeepOpen;
      end
      PhDeepOpen: st_phase = PhDeepPump;
      PhDeepPump: st_phase = PhDeepDrain;
      PhDeepDrain: begin
        if (st_again) begin
          st_again = 1'b0;
          st_phase = PhDeepOpen;
        end else if (int'(st_pot) + 1 >= PotCount) begin
          st_pot = '0;
          st_phase = PhRest;
        end else begin
          st_pot = st_pot + 2'd1;
          st_phase = PhWarmup;
        end
      end
      default: begin
        st_phase = PhWarmup;
        st_pot = '0;
      end
    endcase
    st_timer = '0;
  endfunction

  // Zero-length waits end in the same step
  function automatic void skip_zero_holds();
    st_timer = '0;
    while (is_timed(st_phase) && hold_len(st_phase) == 18'd0) finish_hold();
  endfunction

  function automatic pws_pkg::result_t step_sequencer(logic op, logic [9:0] moist);
    pws_pkg::result_t r;
    logic [2:0] pot_bit;
    if (st_phase == PhFault) begin
      if (op == OpTick) st_blink = ~st_blink;
    end else if (op == OpSample) begin
      case (st_phase)
        PhCheck: begin
          if (moist < cur_cfg.dry_threshold) begin
            st_phase = PhPreFirst;
          end else begin
            st_again = 1'b0;
            st_phase = PhDeepOpen;
            skip_zero_holds();
          end
        end
        PhPreFirst: begin
          st_travel = '0;
          st_phase = (moist < cur_cfg.wet_threshold &&
                      st_travel < cur_cfg.max_travel_seconds) ? PhOpenLoop : PhOpenDone;
          st_timer = '0;
        end
        PhPreSample: begin
          if (st_travel != CountCap) st_travel = st_travel + 4'd1;
          if (moist < cur_cfg.wet_threshold && st_travel < cur_cfg.max_travel_seconds)
            st_phase = PhPrePump;
          else
            close_pre_loop();
          st_timer = '0;
        end
        default: ;
      endcase
    end else if (is_timed(st_phase)) begin
      st_timer = st_timer + 18'd1;
      if (st_timer >= hold_len(st_phase)) begin
        finish_hold();
        skip_zero_holds();
      end
    end

    // Outputs follow the stage reached
    pot_bit = 3'b001 << st_pot;
    r = '0;
    r.active_pot = st_pot;
    case (st_phase)
      PhWarmup, PhSettle: r.sensor_power_mask = pot_bit;
      PhCheck, PhPreFirst: begin
        r.sensor_power_mask = pot_bit;
        r.sample_request = 1'b1;
      end
      PhOpenLoop, PhOpenDone, PhPreDrain, PhDeepOpen, PhDeepDrain: begin
        r.sensor_power_mask = pot_bit;
        r.valve_mask = pot_bit;
      end
      PhPrePump, PhDeepPump: begin
        r.sensor_power_mask = pot_bit;
        r.valve_mask = pot_bit;
        r.pump_on = 1'b1;
      end
      PhPreSample: begin
        r.sensor_power_mask = pot_bit;
        r.valve_mask = pot_bit;
        r.pump_on = 1'b1;
        r.sample_request = 1'b1;
      end
      PhFault: begin
        r.valve_mask = pot_bit;
        r.pump_on = (st_travel != '0);
        r.sensor_power_mask = st_blink ? AllPots : 3'b000;
        r.fault_leds = st_blink ? LedsLit : 3'b000;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Reading below or at/above a threshold, often right at the boundary
  function automatic logic [9:0] moisture_vs(logic [9:0] thr, bit under);
    if (under && thr != '0)
      return ($urandom_range(3) == 0) ? thr - 10'd1 : 10'($urandom_range(thr - 1, 0));
    return ($urandom_range(3) == 0) ? thr : 10'($urandom_range(1023, thr));
  endfunction

  // Picks the event the sequencer waits for, with some wrong events mixed in.
  // Outside a fault run the pre-water pass is always ended wet below the limit.
  task automatic choose_event(input bit aim_fault, output logic op, output logic [9:0] moist);
    bit want_sample;
    logic [3:0] next_count;
    want_sample = st_phase inside {PhCheck, PhPreFirst, PhPreSample};
    next_count = (st_travel != CountCap) ? st_travel + 4'd1 : CountCap;
    moist = 10'($urandom);
    if (st_phase == PhFault) begin
      op = 1'($urandom_range(1));
    end else if ($urandom_range(9) == 0) begin
      op = want_sample ? OpTick : OpSample;
    end else if (!want_sample) begin
      op = OpTick;
    end else begin
      op = OpSample;
      case (st_phase)
        PhCheck:
          moist = moisture_vs(cur_cfg.dry_threshold, aim_fault || $urandom_range(1) == 1);
        PhPreFirst:
          moist = moisture_vs(cur_cfg.wet_threshold, aim_fault ||
                              (cur_cfg.max_travel_seconds >= 4'd2 && $urandom_range(1) == 1));
        default: begin
          if (aim_fault)
            moist = moisture_vs(cur_cfg.wet_threshold,
                                next_count < cur_cfg.max_travel_seconds);
          else if (int'(next_count) + 1 >= int'(cur_cfg.max_travel_seconds))
            moist = moisture_vs(cur_cfg.wet_threshold, 1'b0);
          else
            moist = moisture_vs(cur_cfg.wet_threshold, $urandom_range(4) < 3);
        end
      endcase
    end
  endtask

  // One input transfer, optionally after a random gap
  task automatic apply_event(input logic op, input logic [9:0] moist);
    int gap;
    gap = (calm || gapless || $urandom_range(3) != 0) ? 0 : $urandom_range(8, 1);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    moisture_i <= moist;
    do @(posedge clk_i); while (in_stall_o);
    due_outputs.push_back(step_sequencer(op, moist));
  endtask

  task automatic run_guided(input int n, input bit aim_fault);
    logic op;
    logic [9:0] moist;
    repeat (n) begin
      choose_event(aim_fault, op, moist);
      apply_event(op, moist);
    end
  endtask

  // Stop sending and wait for every predicted result
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Register write; bits above the register width are sometimes filled with junk
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [17:0] value);
    logic [17:0] data;
    int w;
    case (idx)
      RegDryThreshold, RegWetThreshold: w = 10;
      RegSettle:                        w = 8;
      RegRest:                          w = 18;
      default:                          w = 4;
    endcase
    data = value;
    if ($urandom_range(1) == 1) data = data | (18'($urandom) & ~((18'd1 << w) - 18'd1));
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegDryThreshold: cur_cfg.dry_threshold = data[9:0];
      RegWetThreshold: cur_cfg.wet_threshold = data[9:0];
      RegMaxTravel:    cur_cfg.max_travel_seconds = data[3:0];
      RegSoakExtra:    cur_cfg.soak_extra_seconds = data[3:0];
      RegSettle:       cur_cfg.settle_seconds = data[7:0];
      RegRest:         cur_cfg.rest_seconds = data;
      RegWarmup:       cur_cfg.warmup_seconds = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Leaves any pre-water pass first so a new limit cannot force a fault
  task automatic configure(input logic [17:0] dry, input logic [17:0] wet,
                           input logic [17:0] travel_limit, input logic [17:0] soak,
                           input logic [17:0] settle, input logic [17:0] rest,
                           input logic [17:0] warmup);
    while (st_phase inside {PhOpenLoop, PhOpenDone, PhPrePump, PhPreSample})
      run_guided(1, 1'b0);
    drain_block();
    write_reg(RegDryThreshold, dry);
    write_reg(RegWetThreshold, wet);
    write_reg(RegMaxTravel, travel_limit);
    write_reg(RegSoakExtra, soak);
    write_reg(RegSettle, settle);
    write_reg(RegRest, rest);
    write_reg(RegWarmup, warmup);
  endtask

  task automatic configure_random();
    configure(18'($urandom_range(1023)), 18'($urandom_range(1023)),
              18'($urandom_range(15, 1)), 18'($urandom_range(15)),
              18'($urandom_range(12)), 18'($urandom_range(40)),
              18'($urandom_range(15)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values, wrong events and threshold boundaries, hand-picked
  task automatic test_directed_defaults();
    apply_event(OpSample, 10'd512);   // sample during warm-up: ignored
    apply_event(OpTick, 10'd0);       // warm-up ends, sample awaited
    apply_event(OpTick, 10'h3ff);     // tick while a sample is awaited: ignored
    apply_event(OpSample, 10'd199);   // just under the dry threshold
    apply_event(OpSample, 10'd599);   // under wet: valve opens
    apply_event(OpTick, 10'd0);
    apply_event(OpTick, 10'd0);
    apply_event(OpSample, 10'd0);
    apply_event(OpTick, 10'd0);
    apply_event(OpSample, 10'd600);   // wet right at the threshold
    apply_event(OpTick, 10'h155);
    apply_event(OpTick, 10'h2aa);     // travel time stored, settle starts
    // cut the settle wait short while it runs
    drain_block();
    write_reg(RegSettle, 18'd0);
    apply_event(OpTick, 10'd0);
    apply_event(OpSample, 10'h3ff);   // sample during deep watering: ignored
  endtask

  // All configured waits zero, every sample wet
  task automatic test_zero_waits();
    configure(18'd1023, 18'd0, 18'd1, 18'd0, 18'd0, 18'd0, 18'd0);
    run_guided(120, 1'b0);
  endtask

  // Upper ends of the wait registers, no pot ever dry
  task automatic test_long_waits();
    configure(18'd0, 18'd1023, 18'd15, 18'd15, 18'd255, 18'd262143, 18'd15);
    run_guided(250, 1'b0);
  endtask

  // Long pre-water passes under the highest travel limit
  task automatic test_long_prewater();
    configure(18'd1023, 18'd1023, 18'd15, 18'd1, 18'd1, 18'd2, 18'd2);
    run_guided(250, 1'b0);
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    gapless = 1'b1;
    long_hold_req = 1'b1;
    run_guided(16, 1'b0);
    while (long_hold_req) @(posedge clk_i);
    gapless = 1'b0;
  endtask

  // Sender pauses until the block has nothing left to deliver
  task automatic test_drain_pause();
    run_guided(30, 1'b0);
    drain_block();
    run_guided(30, 1'b0);
  endtask

  task automatic test_random_settings();
    for (int round = 0; round < 5; round++) begin
      configure_random();
      run_guided(150, 1'b0);
    end
  endtask

  task automatic test_steady_flow();
    configure_random();
    run_guided(150, 1'b0);
  endtask

  // Drive a dry pot into the permanent fault, then let the lights blink.
  // Either a zero limit or a count limit reached on a wet sample.
  task automatic test_fault();
    int guard;
    bit zero_limit;
    zero_limit = 1'($urandom_range(1));
    configure(18'd1023, 18'd1023, zero_limit ? 18'd0 : 18'($urandom_range(4, 2)),
              18'd0, 18'd0, 18'd0, 18'd0);
    guard = 0;
    while (st_phase != PhFault && guard < 600) begin
      run_guided(1, 1'b1);
      guard++;
    end
    run_guided(40, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------

  task automatic log_failure(input string msg);
    error_count++;
    if (error_count <= MaxReported) $display("%0t: %s", $realtime, msg);
  endtask

  initial begin
    pws_pkg::result_t got;
    pws_pkg::result_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got = {valve_mask_o, pump_on_o, sensor_power_mask_o, sample_request_o,
               active_pot_o, fault_leds_o};
        if (due_outputs.size() == 0) begin
          log_failure($sformatf("unexpected result transfer %p", got));
        end else begin
          want = due_outputs.pop_front();
          if (got.valve_mask !== want.valve_mask || got.pump_on !== want.pump_on ||
              got.sensor_power_mask !== want.sensor_power_mask ||
              got.sample_request !== want.sample_request ||
              got.active_pot !== want.active_pot || got.fault_leds !== want.fault_leds)
            log_failure($sformatf(
              "mismatch: valve %b/%b pump %b/%b power %b/%b req %b/%b pot %0d/%0d leds %b/%b (exp/got)",
              want.valve_mask, got.valve_mask, want.pump_on, got.pump_on,
              want.sensor_power_mask, got.sensor_power_mask,
              want.sample_request, got.sample_request,
              want.active_pot, got.active_pot, want.fault_leds, got.fault_leds));
        end
      end
    end
  end

  // Output stall: random bursts, or one long hold-off on request
  initial begin
    int span;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else begin
        span = $urandom_range(8, 1);
        out_stall_i <= !calm && ($urandom_range(2) == 0);
        repeat (span - 1) @(negedge clk_i);
      end
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_defaults();
    test_zero_waits();
    test_long_waits();
    test_long_prewater();
    test_backpressure();
    test_drain_pause();
    test_random_settings();
    // no idling on either side from here on
    calm = 1'b1;
    test_steady_flow();
    test_fault();

    drain_block();
    repeat (5) @(posedge clk_i);
    if (error_count == 0 && due_outputs.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[plant_watering_sequencer_top.f]
src/pws_pkg.sv
src/pws_core.sv
src/pws_skid.sv
src/plant_watering_sequencer_top.sv
dv/plant_watering_sequencer_top_test.sv
